FILE: hw/rtl/mbs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the Mandelbrot pixel shader.
// No dependencies; used by the interfaces, the top level and the checker.
package mbs_pkg;

    localparam int IDX_W   = 24;   // pixel index / pixel number
    localparam int GRAY_W  = 8;
    localparam int DIMC_W  = 13;   // width and height registers
    localparam int LIMIT_W = 16;
    localparam int COORD_W = 64;
    localparam int CFG_W   = 64;
    localparam int CFGI_W  = 3;

    // shared restoring divider: 88-bit dividend, 16-bit divisor
    localparam int NUM_W   = 88;
    localparam int DIV_W   = 16;
    localparam int DCNT_W  = 7;

    // register indexes of the configuration port
    localparam logic [CFGI_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFGI_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFGI_W-1:0] REG_LEFT   = 3'd2;
    localparam logic [CFGI_W-1:0] REG_RIGHT  = 3'd3;
    localparam logic [CFGI_W-1:0] REG_TOP    = 3'd4;
    localparam logic [CFGI_W-1:0] REG_BOTTOM = 3'd5;
    localparam logic [CFGI_W-1:0] REG_LIMIT  = 3'd6;

    // reset view
    localparam logic [DIMC_W-1:0]         RST_WIDTH  = 13'd1920;
    localparam logic [DIMC_W-1:0]         RST_HEIGHT = 13'd1080;
    localparam logic signed [COORD_W-1:0] RST_LEFT   = -64'sd820395884248140171;
    localparam logic signed [COORD_W-1:0] RST_RIGHT  = -64'sd820375131661057248;
    localparam logic signed [COORD_W-1:0] RST_TOP    = 64'sd290689557721038149;
    localparam logic signed [COORD_W-1:0] RST_BOTTOM = 64'sd290701086936084217;
    localparam logic [LIMIT_W-1:0]        RST_LIMIT  = 16'd800;

    // clamp a 130-bit two's complement value to the signed 64-bit range
    function automatic logic signed [COORD_W-1:0] sat64(input logic [129:0] v);
        logic signed [COORD_W-1:0] r;
        if ((&v[129:63]) || (~|v[129:63])) begin
            r = v[63:0];
        end else if (v[129]) begin
            r = {1'b1, 63'b0};
        end else begin
            r = {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/mbs_pix_if.sv
`timescale 1ns / 1ps
// Input channel: one pixel index per transfer.
// Depends on mbs_pkg.
interface mbs_pix_if;
    logic                       valid;
    logic                       ready;
    logic [mbs_pkg::IDX_W-1:0]  pixel_index;

    modport source (output valid, output pixel_index, input ready);
    modport sink   (input valid, input pixel_index, output ready);
endinterface

FILE: hw/rtl/mbs_shade_if.sv
`timescale 1ns / 1ps
// Result channel: pixel number and gray level per transfer.
// Depends on mbs_pkg.
interface mbs_shade_if;
    logic                        valid;
    logic                        ready;
    logic [mbs_pkg::IDX_W-1:0]   pixel_number;
    logic [mbs_pkg::GRAY_W-1:0]  gray_level;

    modport source (output valid, output pixel_number, output gray_level, input ready);
    modport sink   (input valid, input pixel_number, input gray_level, output ready);
endinterface

FILE: hw/rtl/mandelbrot_pixel_shade_top.sv
`timescale 1ns / 1ps
// Mandelbrot escape-time shader, running at most the iteration limit of iterations per
// pixel: one 32x32 multiplier builds each 64x64 product, three per iteration, and
// a radix-2 divider takes 24 steps for the split and the gray scaling and 88 per
// mapping. A zero column or row, or a width or height of one, skips its mapping.
// One pixel in flight; a result may wait in the output register while the next
// index is taken. Synchronous active-low reset: idle, output empty, reset view.
module mandelbrot_pixel_shade_top #(
    parameter int MAX_DIMENSION = 4096,
    parameter int FRACTION_BITS = 60
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [mbs_pkg::CFGI_W-1:0]   i_cfg_index,
    input  logic [mbs_pkg::CFG_W-1:0]    i_cfg_wdata,
    mbs_pix_if.sink                      i_pix,
    mbs_shade_if.source                  o_shade
);

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam logic [127:0] BOUND = 128'(1) << (2 + 2 * FRACTION_BITS);

    typedef enum logic [4:0] {
        S_IDLE, S_DIV, S_MUL, S_SPLIT,
        S_MAP0, S_MAP1, S_MAP2, S_MAP3,
        S_IT0, S_IT1, S_IT2, S_IT3, S_IT4,
        S_GRAY0, S_GRAY1, S_DONE
    } t_state;

    // configuration
    logic [mbs_pkg::DIMC_W-1:0]          r_width, r_height;
    logic signed [mbs_pkg::COORD_W-1:0]  r_left, r_right, r_top, r_bottom;
    logic [mbs_pkg::LIMIT_W-1:0]         r_limit;

    // sequencer and datapath
    t_state                              r_state, r_ret;
    logic [mbs_pkg::IDX_W-1:0]           r_idx, r_row;
    logic [DIM_W-1:0]                    r_col;
    logic                                r_axis, r_negd;
    logic [63:0]                         r_ma, r_mb, r_prod;
    logic [2:0]                          r_mstep;
    logic [1:0]                          r_psh;
    logic [127:0]                        r_acc, r_xx, r_yy;
    logic [mbs_pkg::NUM_W-1:0]           r_dnum;
    logic [mbs_pkg::DIV_W-1:0]           r_drem, r_dden;
    logic [mbs_pkg::DCNT_W-1:0]          r_dcnt;
    logic signed [88:0]                  r_qs;
    logic signed [mbs_pkg::COORD_W-1:0]  r_cx, r_cy, r_x, r_y;
    logic signed [127:0]                 r_t0, r_t1;
    logic [mbs_pkg::LIMIT_W-1:0]         r_count;
    logic [mbs_pkg::GRAY_W-1:0]          r_gray, r_ogray;
    logic [mbs_pkg::IDX_W-1:0]           r_onum;
    logic                                r_ovalid;

    logic [DIM_W-1:0]                    w_cl, h_cl, span;
    logic [31:0]                         m_a, m_b;
    logic [63:0]                         m_p;
    logic [127:0]                        acc_add;
    logic [mbs_pkg::DIV_W:0]             d_sh, d_sub;
    logic                                d_ge;
    logic [mbs_pkg::DIV_W-1:0]           d_rem;
    logic signed [mbs_pkg::COORD_W-1:0]  e0, e1;
    logic [mbs_pkg::IDX_W-1:0]           k;
    logic [64:0]                         diff, diff_mag;
    logic [63:0]                         abs_x, abs_y;
    logic signed [127:0]                 c_diff, c_xy;
    logic [88:0]                         q_up;
    logic [129:0]                        map_sum;
    logic [mbs_pkg::IDX_W-1:0]           scaled;

    // dimensions, with zero read as one and the top clamped
    always_comb begin
        if (r_width == '0) begin
            w_cl = DIM_W'(1);
        end else if (32'(r_width) > 32'(MAX_DIMENSION)) begin
            w_cl = DIM_W'(MAX_DIMENSION);
        end else begin
            w_cl = DIM_W'(r_width);
        end
        if (r_height == '0) begin
            h_cl = DIM_W'(1);
        end else if (32'(r_height) > 32'(MAX_DIMENSION)) begin
            h_cl = DIM_W'(MAX_DIMENSION);
        end else begin
            h_cl = DIM_W'(r_height);
        end
    end

    // shared multiplier: partial products lo*lo, lo*hi, hi*lo, hi*hi
    assign m_a     = r_mstep[1] ? r_ma[63:32] : r_ma[31:0];
    assign m_b     = r_mstep[0] ? r_mb[63:32] : r_mb[31:0];
    assign m_p     = m_a * m_b;
    assign acc_add = r_acc + ({64'b0, r_prod} << {r_psh, 5'b0});

    // shared divider step
    assign d_sh  = {r_drem, r_dnum[mbs_pkg::NUM_W-1]};
    assign d_ge  = d_sh >= {1'b0, r_dden};
    assign d_sub = d_sh - {1'b0, r_dden};
    assign d_rem = d_ge ? d_sub[mbs_pkg::DIV_W-1:0] : d_sh[mbs_pkg::DIV_W-1:0];

    // mapping operands of the current axis
    assign e0       = r_axis ? r_top : r_left;
    assign e1       = r_axis ? r_bottom : r_right;
    assign k        = r_axis ? r_row : mbs_pkg::IDX_W'(r_col);
    assign span     = r_axis ? (h_cl - DIM_W'(1)) : (w_cl - DIM_W'(1));
    assign diff     = {e1[63], e1} - {e0[63], e0};
    assign diff_mag = diff[64] ? (65'd0 - diff) : diff;
    assign q_up     = {1'b0, r_dnum} + 89'(r_drem != '0);
    assign map_sum  = {{66{e0[63]}}, e0} + {{41{r_qs[88]}}, r_qs};

    assign abs_x  = r_x[63] ? (64'd0 - r_x) : r_x;
    assign abs_y  = r_y[63] ? (64'd0 - r_y) : r_y;
    assign c_diff = r_xx - r_yy;
    assign c_xy   = (r_x[63] ^ r_y[63]) ? (128'd0 - r_acc) : r_acc;
    assign scaled = {r_count, 8'b0} - mbs_pkg::IDX_W'(r_count);

    assign i_pix.ready          = (r_state == S_IDLE);
    assign o_shade.valid        = r_ovalid;
    assign o_shade.pixel_number = r_onum;
    assign o_shade.gray_level   = r_ogray;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= mbs_pkg::RST_WIDTH;
            r_height <= mbs_pkg::RST_HEIGHT;
            r_left   <= mbs_pkg::RST_LEFT;
            r_right  <= mbs_pkg::RST_RIGHT;
            r_top    <= mbs_pkg::RST_TOP;
            r_bottom <= mbs_pkg::RST_BOTTOM;
            r_limit  <= mbs_pkg::RST_LIMIT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mbs_pkg::REG_WIDTH:  r_width  <= i_cfg_wdata[mbs_pkg::DIMC_W-1:0];
                mbs_pkg::REG_HEIGHT: r_height <= i_cfg_wdata[mbs_pkg::DIMC_W-1:0];
                mbs_pkg::REG_LEFT:   r_left   <= i_cfg_wdata;
                mbs_pkg::REG_RIGHT:  r_right  <= i_cfg_wdata;
                mbs_pkg::REG_TOP:    r_top    <= i_cfg_wdata;
                mbs_pkg::REG_BOTTOM: r_bottom <= i_cfg_wdata;
                mbs_pkg::REG_LIMIT:  r_limit  <= i_cfg_wdata[mbs_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_ovalid || o_shade.ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_shade.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_pix.valid) begin
                        r_idx   <= i_pix.pixel_index;
                        r_dnum  <= {i_pix.pixel_index, 64'b0};
                        r_drem  <= '0;
                        r_dden  <= mbs_pkg::DIV_W'(w_cl);
                        r_dcnt  <= mbs_pkg::DCNT_W'(mbs_pkg::IDX_W);
                        r_ret   <= S_SPLIT;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dnum <= {r_dnum[mbs_pkg::NUM_W-2:0], d_ge};
                    r_drem <= d_rem;
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == mbs_pkg::DCNT_W'(1)) begin
                        r_state <= r_ret;
                    end
                end
                S_MUL: begin
                    // product issued at step s is accumulated at step s+1
                    r_prod  <= m_p;
                    r_psh   <= {1'b0, r_mstep[0]} + {1'b0, r_mstep[1]};
                    r_mstep <= r_mstep + 1'b1;
                    if (r_mstep == 3'd0) begin
                        r_acc <= '0;
                    end else begin
                        r_acc <= acc_add;
                    end
                    if (r_mstep == 3'd4) begin
                        r_state <= r_ret;
                    end
                end
                S_SPLIT: begin
                    r_row   <= r_dnum[mbs_pkg::IDX_W-1:0];
                    r_col   <= DIM_W'(r_drem);
                    r_axis  <= 1'b0;
                    r_state <= S_MAP0;
                end
                S_MAP0: begin
                    if (span == '0 || k == '0) begin
                        r_qs    <= '0;
                        r_state <= S_MAP3;
                    end else begin
                        r_negd  <= diff[64];
                        r_ma    <= diff_mag[63:0];
                        r_mb    <= 64'(k);
                        r_mstep <= '0;
                        r_ret   <= S_MAP1;
                        r_state <= S_MUL;
                    end
                end
                S_MAP1: begin
                    r_dnum  <= r_acc[mbs_pkg::NUM_W-1:0];
                    r_drem  <= '0;
                    r_dden  <= mbs_pkg::DIV_W'(span);
                    r_dcnt  <= mbs_pkg::DCNT_W'(mbs_pkg::NUM_W);
                    r_ret   <= S_MAP2;
                    r_state <= S_DIV;
                end
                S_MAP2: begin
                    // negative slope: floor is minus the ceiling of the magnitude
                    if (r_negd) begin
                        r_qs <= 89'd0 - q_up;
                    end else begin
                        r_qs <= {1'b0, r_dnum};
                    end
                    r_state <= S_MAP3;
                end
                S_MAP3: begin
                    if (!r_axis) begin
                        r_cx    <= mbs_pkg::sat64(map_sum);
                        r_axis  <= 1'b1;
                        r_state <= S_MAP0;
                    end else begin
                        r_cy    <= mbs_pkg::sat64(map_sum);
                        r_x     <= '0;
                        r_y     <= '0;
                        r_count <= '0;
                        r_state <= S_IT0;
                    end
                end
                S_IT0: begin
                    if (r_count == r_limit) begin
                        r_state <= S_GRAY0;
                    end else begin
                        r_ma    <= abs_x;
                        r_mb    <= abs_x;
                        r_mstep <= '0;
                        r_ret   <= S_IT1;
                        r_state <= S_MUL;
                    end
                end
                S_IT1: begin
                    r_xx    <= r_acc;
                    r_ma    <= abs_y;
                    r_mb    <= abs_y;
                    r_mstep <= '0;
                    r_ret   <= S_IT2;
                    r_state <= S_MUL;
                end
                S_IT2: begin
                    r_yy <= r_acc;
                    if ((r_xx + r_acc) >= BOUND) begin
                        r_state <= S_GRAY0;
                    end else begin
                        r_ma    <= abs_x;
                        r_mb    <= abs_y;
                        r_mstep <= '0;
                        r_ret   <= S_IT3;
                        r_state <= S_MUL;
                    end
                end
                S_IT3: begin
                    r_t0    <= c_diff >>> FRACTION_BITS;
                    r_t1    <= c_xy >>> (FRACTION_BITS - 1);
                    r_state <= S_IT4;
                end
                S_IT4: begin
                    r_x     <= mbs_pkg::sat64({{2{r_t0[127]}}, r_t0} + {{66{r_cx[63]}}, r_cx});
                    r_y     <= mbs_pkg::sat64({{2{r_t1[127]}}, r_t1} + {{66{r_cy[63]}}, r_cy});
                    r_count <= r_count + 1'b1;
                    r_state <= S_IT0;
                end
                S_GRAY0: begin
                    if (r_limit == '0) begin
                        r_gray  <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_dnum  <= {scaled, 64'b0};
                        r_drem  <= '0;
                        r_dden  <= r_limit;
                        r_dcnt  <= mbs_pkg::DCNT_W'(mbs_pkg::IDX_W);
                        r_ret   <= S_GRAY1;
                        r_state <= S_DIV;
                    end
                end
                S_GRAY1: begin
                    r_gray  <= r_dnum[mbs_pkg::GRAY_W-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || o_shade.ready) begin
                        r_onum   <= r_idx;
                        r_ogray  <= r_gray;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hw/rtl/mbs_chk.sv
`timescale 1ns / 1ps
// Port-level checks of the Mandelbrot pixel shader, bound to its top level.
// Depends on mbs_pkg and mandelbrot_pixel_shade_top.
module mbs_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [mbs_pkg::IDX_W-1:0]     i_out_number,
    input logic [mbs_pkg::GRAY_W-1:0]    i_out_gray
);

    // one pixel in flight: busy straight after a transfer in
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still ready after a transfer");

    // a fresh result is only loaded while a pixel is being worked on
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a pixel in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_number) && $stable(i_out_gray)))
        else $error("stalled result changed");

endmodule

bind mandelbrot_pixel_shade_top mbs_chk u_mbs_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_shade.valid),
    .i_out_ready  (o_shade.ready),
    .i_out_number (o_shade.pixel_number),
    .i_out_gray   (o_shade.gray_level)
);
